>>> rtl/ictp_pkg.sv
// ----------------------------------------------------------------------------
// ictp_pkg: shared types and constants of the instruction predecoder
// Transfer types, class and offset-form codes, and opcode pattern constants.
// ----------------------------------------------------------------------------
package ictp_pkg;

  typedef enum logic [3:0] {
    CLS_PLAIN    = 4'd0,
    CLS_LITERAL  = 4'd1,
    CLS_CALL     = 4'd2,
    CLS_REGCALL  = 4'd3,
    CLS_WREGCALL = 4'd4,
    CLS_RETURN   = 4'd5,
    CLS_BRANCH   = 4'd6,
    CLS_JUMP     = 4'd7,
    CLS_REGJUMP  = 4'd8,
    CLS_ILLEGAL  = 4'd9
  } cls_t;

  typedef enum logic [2:0] {
    FORM_NONE  = 3'd0,
    FORM_IMM6  = 3'd1,
    FORM_IMM8  = 3'd2,
    FORM_IMM12 = 3'd3,
    FORM_IMM16 = 3'd4,
    FORM_IMM18 = 3'd5,
    FORM_CALL  = 3'd6
  } form_t;

  typedef struct packed {
    logic [31:0] instr_address;
    logic [23:0] instr_bytes;
  } instr_t;

  typedef struct packed {
    cls_t        instr_class;
    logic [1:0]  instr_length;
    logic        target_valid;
    logic [31:0] target_address;
    form_t       offset_form;
  } result_t;

  // Target side of one decoded instruction.
  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    form_t       form;
  } tgt_t;

  localparam logic [7:0]  LEN_NARROW  = 8'h08;
  localparam logic [7:0]  BR_NARROW_M = 8'h8F;
  localparam logic [7:0]  BR_NARROW_V = 8'h8C;
  localparam logic [7:0]  MOVI_A      = 8'h36;
  localparam logic [7:0]  MOVI_B      = 8'h76;
  localparam logic [7:0]  BR12_V      = 8'h16;
  localparam logic [7:0]  BR12_XA     = 8'hB6;
  localparam logic [7:0]  BR12_XB     = 8'hF6;
  localparam logic [23:0] REG_MASK    = 24'hFFF0FF;
  localparam logic [23:0] WCALL_MASK  = 24'hFFFFCF;
  localparam logic [23:0] RET_W       = 24'h000080;
  localparam logic [23:0] JX_W        = 24'h0000A0;
  localparam logic [23:0] CALLX_W     = 24'h0000C0;
  localparam logic [23:0] RFE_W       = 24'h003010;
  localparam logic [23:0] RFX_W       = 24'h003000;
  localparam logic [23:0] RFI_W       = 24'hF17010;
  localparam logic [15:0] RETN_H      = 16'hF00D;
  localparam logic [15:0] ILLN_H      = 16'hF06D;
  localparam logic [13:0] LIT_HIGH    = 14'h3FFF;

endpackage

>>> rtl/ictp_classify.sv
// ----------------------------------------------------------------------------
// ictp_classify: opcode pattern classifier
// Maps the three code bytes to an instruction class, first match wins.
// ----------------------------------------------------------------------------
module ictp_classify (
  input  logic [23:0]     instr_bytes,
  output ictp_pkg::cls_t  instr_class
);
  import ictp_pkg::*;

  logic [7:0]  b0;
  logic [23:0] r;

  assign b0 = instr_bytes[7:0];
  assign r  = instr_bytes & REG_MASK;

  always_comb begin
    priority if (b0[3:0] == 4'h1) begin
      instr_class = CLS_LITERAL;
    end else if (b0[5:0] == 6'h05) begin
      instr_class = CLS_CALL;
    end else if (b0[5:0] == 6'h06) begin
      instr_class = CLS_JUMP;
    end else if (b0 == MOVI_A || b0 == MOVI_B) begin
      instr_class = CLS_PLAIN;
    end else if (b0[3:1] == 3'b011) begin
      instr_class = CLS_BRANCH;
    end else if ((b0 & BR_NARROW_M) == BR_NARROW_V) begin
      instr_class = CLS_BRANCH;
    end else if (instr_bytes == RET_W) begin
      instr_class = CLS_RETURN;
    end else if (instr_bytes == 24'd0) begin
      instr_class = CLS_ILLEGAL;
    end else if (r == RET_W) begin
      instr_class = CLS_RETURN;
    end else if (r == JX_W) begin
      instr_class = CLS_REGJUMP;
    end else if (r == CALLX_W) begin
      instr_class = CLS_REGCALL;
    end else if (r == RFE_W || r == RFX_W || r == RFI_W) begin
      instr_class = CLS_RETURN;
    end else if ((r & WCALL_MASK) == CALLX_W) begin
      instr_class = CLS_WREGCALL;
    end else if (instr_bytes[15:0] == RETN_H) begin
      instr_class = CLS_RETURN;
    end else if (instr_bytes[15:0] == ILLN_H) begin
      instr_class = CLS_ILLEGAL;
    end else begin
      instr_class = CLS_PLAIN;
    end
  end

endmodule

>>> rtl/ictp_target.sv
// ----------------------------------------------------------------------------
// ictp_target: target address unit
// Picks the offset form, extends the offset and adds it to the address base.
// ----------------------------------------------------------------------------
module ictp_target (
  input  logic [31:0]     instr_address,
  input  logic [23:0]     instr_bytes,
  input  ictp_pkg::cls_t  instr_class,
  output ictp_pkg::tgt_t  tgt
);
  import ictp_pkg::*;

  logic [7:0]  b0;
  logic [31:0] base;
  logic [31:0] offset;
  logic [31:0] inc;
  logic        rnd;

  assign b0  = instr_bytes[7:0];
  assign rnd = (instr_address[1:0] != 2'b00);

  // One adder: base + extended offset + small increment.
  always_comb begin
    base        = instr_address;
    offset      = 32'd0;
    inc         = 32'd4;
    tgt.valid   = 1'b1;
    tgt.form    = FORM_NONE;
    unique case (instr_class)
      CLS_BRANCH: begin
        if ((b0 & LEN_NARROW) != 8'd0) begin
          offset   = {26'd0, b0[5:4], instr_bytes[15:12]};
          tgt.form = FORM_IMM6;
        end else if (b0[4:0] == BR12_V[4:0] && b0 != BR12_XA && b0 != BR12_XB) begin
          offset   = {{20{instr_bytes[23]}}, instr_bytes[23:12]};
          tgt.form = FORM_IMM12;
        end else begin
          offset   = {{24{instr_bytes[23]}}, instr_bytes[23:16]};
          tgt.form = FORM_IMM8;
        end
      end
      CLS_JUMP: begin
        offset   = {{14{instr_bytes[23]}}, instr_bytes[23:6]};
        tgt.form = FORM_IMM18;
      end
      CLS_CALL: begin
        base     = {instr_address[31:2], 2'b00};
        offset   = {{12{instr_bytes[23]}}, instr_bytes[23:6], 2'b00};
        tgt.form = FORM_CALL;
      end
      CLS_LITERAL: begin
        // Round the address up to a word, then add the negative pool offset.
        base     = {instr_address[31:2], 2'b00};
        offset   = {LIT_HIGH, instr_bytes[23:8], 2'b00};
        inc      = {29'd0, rnd, 2'b00};
        tgt.form = FORM_IMM16;
      end
      default: begin
        base      = 32'd0;
        inc       = 32'd0;
        tgt.valid = 1'b0;
      end
    endcase
    tgt.address = base + offset + inc;
  end

endmodule

>>> rtl/instruction_class_and_target_predecode.sv
// ----------------------------------------------------------------------------
// instruction_class_and_target_predecode: instruction class and target predecoder
// Classifies one instruction per transfer and computes its length and target.
// ----------------------------------------------------------------------------
// Path: each item is registered in the input register and then in the result
//   register; a consumer stall can hold it in either.
// Throughput: 1 instruction per cycle unless the consumer stalls; decode is one
//   pass of short logic between the input register and the result register.
// Reset: rst empties both registers; no other state is kept between items.
// ----------------------------------------------------------------------------
module instruction_class_and_target_predecode (
  input  logic                clk,
  input  logic                rst,
  input  logic                instr_valid,
  output logic                instr_stall,
  input  ictp_pkg::instr_t    instr,
  output logic                result_valid,
  input  logic                result_stall,
  output ictp_pkg::result_t   result
);
  import ictp_pkg::*;

  // Input register.
  logic   s1_valid;
  instr_t s1;

  // Handshake control.
  logic out_hold;
  logic s1_move;
  logic accept;

  // Decode outputs.
  cls_t    cls;
  tgt_t    tgt;
  result_t result_next;

  // Hold the result while the consumer stalls it; the input register then
  // holds too once it is full. Otherwise everything advances every cycle.
  assign out_hold    = result_valid && result_stall;
  assign s1_move     = s1_valid && !out_hold;
  assign instr_stall = s1_valid && out_hold;
  assign accept      = instr_valid && !instr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= instr;
    end
  end

  ictp_classify u_classify (
    .instr_bytes (s1.instr_bytes),
    .instr_class (cls)
  );

  ictp_target u_target (
    .instr_address (s1.instr_address),
    .instr_bytes   (s1.instr_bytes),
    .instr_class   (cls),
    .tgt           (tgt)
  );

  // Length follows bit 3 of the first byte for every class.
  always_comb begin
    result_next.instr_class    = cls;
    result_next.instr_length   = (s1.instr_bytes[3]) ? 2'd2 : 2'd3;
    result_next.target_valid   = tgt.valid;
    result_next.target_address = tgt.address;
    result_next.offset_form    = tgt.form;
  end

  // Result register: load from the input register, drop once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!out_hold) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !result_valid))
    else $error("pipeline not empty after reset");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> result_valid)
    else $error("decoded item lost on its way to the result register");

  a_tgt_class: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.target_valid ==
      (result.instr_class == CLS_LITERAL || result.instr_class == CLS_CALL ||
       result.instr_class == CLS_BRANCH  || result.instr_class == CLS_JUMP)))
    else $error("target valid disagrees with class");

  a_no_tgt_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.target_valid) |->
      (result.target_address == 32'd0 && result.offset_form == FORM_NONE))
    else $error("target fields set without a target");
`endif

endmodule
